// File: sv/correlation_frequency_display_macros.svh
// Assertion helpers used by the datapath RTL.
`ifndef CORRELATION_FREQUENCY_DISPLAY_MACROS_SVH
`define CORRELATION_FREQUENCY_DISPLAY_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CFD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfd assertion failed");

// Next-cycle implication, disabled during reset.
`define CFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfd assertion failed");

`endif

// File: sv/cfd_pkg.sv
package cfd_pkg;

  localparam logic [3:0] NIB_AVG  = 4'hC;
  localparam logic [3:0] NIB_CORR = 4'hD;
  localparam logic [3:0] NIB_MEAS = 4'h8;

  localparam logic [1:0] KIND_AVG    = 2'd0;
  localparam logic [1:0] KIND_CORR   = 2'd1;
  localparam logic [1:0] KIND_MEAS   = 2'd2;
  localparam logic [1:0] KIND_IGNORE = 2'd3;

  localparam logic [3:0] WIDTH_LO  = 4'd4;
  localparam logic [3:0] WIDTH_HI  = 4'd8;
  localparam logic [4:0] WINDOW_LO = 5'd16;
  localparam logic [4:0] WINDOW_HI = 5'd20;

  localparam int          FREQ_BITS = 15;
  localparam logic [14:0] FREQ_NUM  = 15'd32000;
  localparam int          DIV_CW    = 4;
  localparam int          REM_BITS  = 16;

  // x / 10 == (x * 0xCCCD) >> 19 for any 16-bit x
  localparam logic [15:0] RECIP10 = 16'hCCCD;
  localparam int          RECIP_SH = 19;

  localparam int SHOWN_DIGITS = 6;
  localparam int SEG_BITS     = 8;
  localparam int OUT_DATA_W   = 64;
  localparam int OUT_USER_W   = 3;

  typedef struct packed {
    logic ld_word;
    logic mul1;
    logic mul2;
    logic chk;
    logic div_step;
    logic dig_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_meas;
    logic samp_zero;
    logic div_last;
    logic dig_last;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] seg_code(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h98;
      default: s = 8'hFF;
    endcase
    return s;
  endfunction

endpackage

// File: sv/cfd_ctrl.sv
module cfd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  cfd_pkg::sts_t sts,
  output cfd_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DIG  = 3'd5;
  localparam logic [2:0] S_LOAD = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.ld_word = 1'b1;
          state_nxt   = S_MUL1;
        end
      end
      S_MUL1: begin
        if (sts.is_meas) begin
          cmd.mul1  = 1'b1;
          state_nxt = S_MUL2;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.chk   = 1'b1;
        state_nxt = sts.samp_zero ? S_LOAD : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_DIG;
      end
      S_DIG: begin
        cmd.dig_step = 1'b1;
        if (sts.dig_last) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: sv/cfd_datapath.sv
`include "correlation_frequency_display_macros.svh"

module cfd_datapath #(
  parameter int DIGITS     = 6,
  parameter int COUNT_BITS = 20
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [31:0]                        in_tdata,
  input  cfd_pkg::cmd_t                      cmd,
  output cfd_pkg::sts_t                      sts,
  input  logic                               out_tready,
  output logic                               out_tvalid,
  output logic [cfd_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [cfd_pkg::OUT_USER_W-1:0]     out_tuser
);

  localparam int P1_W  = COUNT_BITS + 4;
  localparam int SAMP_W = COUNT_BITS + 9;
  localparam int CMP_W = SAMP_W + 1;
  localparam int DCW   = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  logic [1:0]                      kind_r;
  logic [COUNT_BITS-1:0]           count_r;
  logic [3:0]                      width_r;
  logic [4:0]                      window_r;
  logic [P1_W-1:0]                 prod1_r;
  logic [SAMP_W-1:0]               samp_r;
  logic                            zd_r;
  logic [cfd_pkg::REM_BITS-1:0]    rem_r;
  logic [cfd_pkg::FREQ_BITS-1:0]   quo_r;
  logic [cfd_pkg::DIV_CW-1:0]      div_cnt_r;
  logic [cfd_pkg::FREQ_BITS-1:0]   v_r;
  logic [cfd_pkg::FREQ_BITS-1:0]   freq_r;
  logic [DCW-1:0]                  dig_cnt_r;
  logic [7:0]                      pat_r [DIGITS];
  logic                            out_valid_r;
  logic [cfd_pkg::OUT_DATA_W-1:0]  out_data_r;
  logic [cfd_pkg::OUT_USER_W-1:0]  out_user_r;

  logic [3:0]                      nib;
  logic                            sel;

  // restoring divide, one quotient bit per cycle
  logic [cfd_pkg::REM_BITS:0]      t;
  logic [CMP_W-1:0]                t_ext, samp_ext, diff;
  logic                            qbit;
  logic [cfd_pkg::REM_BITS-1:0]    rem_nxt;
  logic [cfd_pkg::FREQ_BITS-1:0]   quo_nxt;

  // one decimal digit per cycle
  logic [30:0]                     dprod;
  logic [11:0]                     dq;
  logic [cfd_pkg::FREQ_BITS-1:0]   dq10;
  logic [3:0]                      digit;
  logic [7:0]                      seg;

  logic [7:0]                      shown [cfd_pkg::SHOWN_DIGITS];
  logic [cfd_pkg::OUT_DATA_W-1:0]  data_nxt;
  logic                            out_free;

  assign nib = in_tdata[31:28];
  assign sel = in_tdata[18];

  assign t        = {rem_r, quo_r[cfd_pkg::FREQ_BITS-1]};
  assign t_ext    = CMP_W'(t);
  assign samp_ext = CMP_W'(samp_r);
  assign diff     = t_ext - samp_ext;
  assign qbit     = (t_ext >= samp_ext);
  assign rem_nxt  = qbit ? diff[cfd_pkg::REM_BITS-1:0] : t[cfd_pkg::REM_BITS-1:0];
  assign quo_nxt  = {quo_r[cfd_pkg::FREQ_BITS-2:0], qbit};

  assign dprod = 31'(v_r) * 31'(cfd_pkg::RECIP10);
  assign dq    = dprod[30:cfd_pkg::RECIP_SH];
  assign dq10  = cfd_pkg::FREQ_BITS'({dq, 3'b000}) + cfd_pkg::FREQ_BITS'({dq, 1'b0});
  assign digit = 4'(v_r - dq10);
  assign seg   = cfd_pkg::seg_code(digit);

  assign out_free = !out_valid_r || out_tready;

  assign sts.is_meas   = (kind_r == cfd_pkg::KIND_MEAS);
  assign sts.samp_zero = (samp_r == '0);
  assign sts.div_last  = (div_cnt_r == cfd_pkg::DIV_CW'(cfd_pkg::FREQ_BITS - 1));
  assign sts.dig_last  = (dig_cnt_r == DCW'(DIGITS - 1));
  assign sts.out_free  = out_free;

  for (genvar k = 0; k < cfd_pkg::SHOWN_DIGITS; k++) begin : g_shown
    if (k < DIGITS) begin : g_live
      assign shown[k] = pat_r[k];
    end else begin : g_dead
      assign shown[k] = 8'h00;
    end
  end

  always_comb begin
    data_nxt = '0;
    data_nxt[cfd_pkg::FREQ_BITS-1:0] = freq_r;
    for (int k = 0; k < cfd_pkg::SHOWN_DIGITS; k++) begin
      data_nxt[cfd_pkg::FREQ_BITS + cfd_pkg::SEG_BITS*k +: cfd_pkg::SEG_BITS] = shown[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      window_r <= '0;
      freq_r   <= '0;
      zd_r     <= 1'b0;
      kind_r   <= cfd_pkg::KIND_IGNORE;
      for (int i = 0; i < DIGITS; i++) pat_r[i] <= 8'h00;
    end else begin
      if (cmd.ld_word) begin
        zd_r <= 1'b0;
        unique case (nib)
          cfd_pkg::NIB_AVG: begin
            kind_r  <= cfd_pkg::KIND_AVG;
            width_r <= sel ? cfd_pkg::WIDTH_HI : cfd_pkg::WIDTH_LO;
          end
          cfd_pkg::NIB_CORR: begin
            kind_r   <= cfd_pkg::KIND_CORR;
            window_r <= sel ? cfd_pkg::WINDOW_HI : cfd_pkg::WINDOW_LO;
          end
          cfd_pkg::NIB_MEAS: kind_r <= cfd_pkg::KIND_MEAS;
          default:           kind_r <= cfd_pkg::KIND_IGNORE;
        endcase
      end
      if (cmd.chk && (samp_r == '0)) zd_r <= 1'b1;
      if (cmd.div_step && sts.div_last) freq_r <= quo_nxt;
      if (cmd.dig_step) begin
        pat_r[DIGITS-1] <= seg;
        for (int i = 0; i < DIGITS - 1; i++) pat_r[i] <= pat_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_word) count_r <= in_tdata[COUNT_BITS-1:0];
    if (cmd.mul1) prod1_r <= P1_W'(count_r) * P1_W'(width_r);
    if (cmd.mul2) samp_r <= SAMP_W'(prod1_r) * SAMP_W'(window_r);
    if (cmd.chk) begin
      rem_r     <= '0;
      quo_r     <= cfd_pkg::FREQ_NUM;
      div_cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r     <= rem_nxt;
      quo_r     <= quo_nxt;
      div_cnt_r <= div_cnt_r + 1'b1;
      if (sts.div_last) begin
        v_r       <= quo_nxt;
        dig_cnt_r <= '0;
      end
    end
    if (cmd.dig_step) begin
      v_r       <= cfd_pkg::FREQ_BITS'(dq);
      dig_cnt_r <= dig_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= data_nxt;
      out_user_r <= {zd_r, kind_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `CFD_ASSERT_NOW(a_load_free, cmd.load_out, out_free)
  `CFD_ASSERT_NOW(a_div_nonzero, cmd.div_step, samp_r != '0)
  `CFD_ASSERT_NOW(a_zd_meas, out_valid_r && out_user_r[2], out_user_r[1:0] == cfd_pkg::KIND_MEAS)
  `CFD_ASSERT_NOW(a_freq_range, out_valid_r,
                  out_data_r[cfd_pkg::FREQ_BITS-1:0] <= cfd_pkg::FREQ_NUM)
  `CFD_ASSERT_NEXT(a_zd_clear, cmd.ld_word, !zd_r)

endmodule

// File: sv/correlation_frequency_display.sv
// Sequence: a setup or ignored word passes through MUL1 and then LOAD after acceptance, a
// measurement with zero samples through MUL1, MUL2, CHK and LOAD, and a measurement through
// MUL1, MUL2, CHK, the restoring divider (DIV), the one-digit-per-cycle decimal converter (DIG)
// and LOAD. A new word is taken only once the last result is loaded; LOAD waits for the output.
// Reset (rst_n low, synchronous): width, window, frequency and digit patterns clear to zero,
// the controller returns to idle and no result word is pending.
module correlation_frequency_display #(
  parameter int DIGITS     = 6,
  parameter int COUNT_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // data_word
  output logic        out_tvalid,
  input  logic        out_tready,
  // frequency, digit0_segments .. digit5_segments, zero pad
  output logic [63:0] out_tdata,
  // packet_kind, zero_divide
  output logic [2:0]  out_tuser
);

  cfd_pkg::cmd_t cmd;
  cfd_pkg::sts_t sts;

  cfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cfd_datapath #(
    .DIGITS     (DIGITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: bench/tb_correlation_frequency_display.sv
module tb_correlation_frequency_display;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;
  // active-low segment codes for digits 0..9
  localparam logic [9:0][7:0] SEG_LUT = {
    8'h98, 8'h80, 8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
  };

  typedef struct packed {
    logic [1:0]      kind;
    logic            zdiv;
    logic [14:0]     freq;
    logic [5:0][7:0] segs;
  } disp_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // data_word
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // frequency, digit0 .. digit5, pad
  logic [2:0]  out_tuser;       // packet_kind, zero_divide

  correlation_frequency_display u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // predictor state
  logic [3:0]      avg_width;
  logic [4:0]      corr_window;
  logic [14:0]     held_freq;
  logic [5:0][7:0] held_segs;

  logic [31:0]  word_q[$];
  disp_result_t result_q[$];
  disp_result_t want;
  int           words_pushed = 0;
  int           words_taken = 0;
  int           errors = 0;
  int           cycles = 0;
  logic         in_took = 1'b0;
  bit           steady = 1'b0;
  int           hold_req = 0;
  int           hold_seen = 0;
  int           hold_left = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic disp_result_t display_update(input logic [31:0] w);
    disp_result_t r;
    logic [63:0]  samples;
    logic [63:0]  f;
    logic [14:0]  v;
    r.kind = cfd_pkg::KIND_IGNORE;
    r.zdiv = 1'b0;
    case (w[31:28])
      cfd_pkg::NIB_AVG: begin
        r.kind = cfd_pkg::KIND_AVG;
        avg_width = w[18] ? cfd_pkg::WIDTH_HI : cfd_pkg::WIDTH_LO;
      end
      cfd_pkg::NIB_CORR: begin
        r.kind = cfd_pkg::KIND_CORR;
        corr_window = w[18] ? cfd_pkg::WINDOW_HI : cfd_pkg::WINDOW_LO;
      end
      cfd_pkg::NIB_MEAS: begin
        r.kind = cfd_pkg::KIND_MEAS;
        samples = 64'(w[19:0]) * 64'(avg_width) * 64'(corr_window);
        if (samples == 0) begin
          r.zdiv = 1'b1;
        end else begin
          f = 64'd32000 / samples;
          held_freq = f[14:0];
          v = held_freq;
          for (int k = 0; k < 6; k++) begin
            held_segs[k] = SEG_LUT[v % 10];
            v = v / 10;
          end
        end
      end
      default: begin
      end
    endcase
    r.freq = held_freq;
    r.segs = held_segs;
    return r;
  endfunction

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    int          r;
    w = $urandom;
    r = $urandom_range(99);
    if (r < 55) begin
      w[31:28] = cfd_pkg::NIB_MEAS;
      if ($urandom_range(9) != 0) w[19:0] = 20'($urandom_range(0, 300));
    end else if (r < 70) begin
      w[31:28] = cfd_pkg::NIB_AVG;
    end else if (r < 85) begin
      w[31:28] = cfd_pkg::NIB_CORR;
    end
    return w;
  endfunction

  task automatic push_word(input logic [31:0] w);
    word_q.push_back(w);
    words_pushed++;
  endtask

  task automatic drain();
    while (word_q.size() != 0 || words_taken != words_pushed || result_q.size() != 0)
      @(posedge clk);
  endtask

  // sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (word_q.size() != 0 && (steady || $urandom_range(99) >= 20)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= word_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen  <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(99) >= 20);
    end
  end

  // predict on input word, check on output word
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
    in_took <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      result_q.push_back(display_update(in_tdata));
      words_taken++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (result_q.size() == 0) begin
        $error("unexpected result word: tuser %h tdata %h", out_tuser, out_tdata);
        errors++;
      end else begin
        want = result_q.pop_front();
        if (out_tuser[1:0] !== want.kind) begin
          $error("packet_kind: expected %0d, got %0d", want.kind, out_tuser[1:0]);
          errors++;
        end
        if (out_tuser[2] !== want.zdiv) begin
          $error("zero_divide: expected %0d, got %0d", want.zdiv, out_tuser[2]);
          errors++;
        end
        if (out_tdata[14:0] !== want.freq) begin
          $error("frequency: expected %0d, got %0d", want.freq, out_tdata[14:0]);
          errors++;
        end
        for (int k = 0; k < 6; k++) begin
          if (out_tdata[15 + 8*k +: 8] !== want.segs[k]) begin
            $error("digit%0d_segments: expected %h, got %h", k, want.segs[k],
                   out_tdata[15 + 8*k +: 8]);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    avg_width   = '0;
    corr_window = '0;
    held_freq   = '0;
    held_segs   = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_word(32'h8000_0005);   // measure before any setup
    push_word(32'h0000_0000);
    push_word(32'hFFFF_FFFF);
    push_word(32'hC000_0000);   // width 4
    push_word(32'h8000_0001);   // window still zero
    push_word(32'hD004_0000);   // window 20
    push_word(32'h8000_0000);   // zero count
    push_word(32'h8000_0001);
    push_word(32'h800F_FFFF);
    push_word(32'h8000_0007);
    push_word(32'hCFFF_FFFF);   // width 8
    push_word(32'h8FF0_0001);
    push_word(32'hDFFB_FFFF);   // window 16
    push_word(32'h8004_0001);
    push_word(32'h8000_0001);
    push_word(32'hC004_0000);
    push_word(32'h8000_0002);
    push_word(32'hC000_0000);
    push_word(32'h8000_0001);   // largest frequency
    push_word(32'h9000_0003);
    push_word(32'h7FFF_FFFF);
    push_word(32'hE004_0000);
    push_word(32'h1234_5678);
    push_word(32'h8000_0000);
    drain();

    for (int i = 0; i < 150; i++) push_word(random_word());
    hold_req++;
    drain();

    steady = 1'b1;
    for (int i = 0; i < 150; i++) push_word(random_word());
    drain();
    steady = 1'b0;

    for (int i = 0; i < 200; i++) push_word(random_word());
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
